// ===== rtl/core/wbrm_pkg.sv =====
// shared constants and controller/datapath command and status types
// no dependencies
`default_nettype none

package wbrm_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int DATA_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = DATA_W / DIGIT_W;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic div_load_sum;
        logic a_rd;
        logic a_wr;
        logic q_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/wbrm_ifs.sv =====
// valid/ready channel interfaces for the meter's input and result transfers
// no dependencies
`default_nettype none

interface wbrm_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        direction;
    logic [31:0] byte_count;
    logic [31:0] now_secs;

    modport source (output valid, command, direction, byte_count, now_secs, input ready);
    modport sink   (input valid, command, direction, byte_count, now_secs, output ready);
endinterface

interface wbrm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] bytes_per_sec;

    modport source (output valid, bytes_per_sec, input ready);
    modport sink   (input valid, bytes_per_sec, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/windowed_byte_rate_meter.sv =====
// Windowed byte-rate meter with a download and an upload meter, each a ring of
// WINDOW one-second buckets (stamp and byte count) in a 2*WINDOW entry memory.
// An add transfer runs a 4-bit-per-cycle divider to find now_secs mod WINDOW,
// then a read and a read-modify-write of the bucket before ready returns. A
// query does one memory read per bucket through a two-stage age test and
// accumulate, then the divider does the floor division by WINDOW, then the
// result register is loaded.
// The result register holds one answer, so a new transfer is taken while the
// previous answer waits; a second query waits only to load its answer.
// Depends on wbrm_pkg, wbrm_ifs, wbrm_ctrl and wbrm_dp.
`default_nettype none

module windowed_byte_rate_meter #(
    parameter int WINDOW = wbrm_pkg::WINDOW_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    wbrm_in_if.sink         i_in,
    wbrm_out_if.source      o_out
);
    import wbrm_pkg::*;

    t_dp_cmd                    w_cmd;
    t_dp_sts                    w_sts;
    logic [$clog2(WINDOW)-1:0]  w_q_slot;
    logic                       w_in_ready;
    logic                       w_out_valid;
    logic [DATA_W-1:0]          w_bytes_per_sec;

    wbrm_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (w_in_ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_q_slot     (w_q_slot)
    );

    wbrm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_q_slot        (w_q_slot),
        .i_direction     (i_in.direction),
        .i_byte_count    (i_in.byte_count),
        .i_now_secs      (i_in.now_secs),
        .o_out_valid     (w_out_valid),
        .i_out_ready     (o_out.ready),
        .o_bytes_per_sec (w_bytes_per_sec)
    );

    assign i_in.ready          = w_in_ready;
    assign o_out.valid         = w_out_valid;
    assign o_out.bytes_per_sec = w_bytes_per_sec;

endmodule

`default_nettype wire

// ===== rtl/core/wbrm_ctrl.sv =====
// sequencing state machine for add and query transfers
// depends on wbrm_pkg
`default_nettype none

module wbrm_ctrl #(
    parameter int WINDOW = wbrm_pkg::WINDOW_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_command,
    output logic                         o_in_ready,
    input  wire wbrm_pkg::t_dp_sts       i_sts,
    output wbrm_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(WINDOW)-1:0]    o_q_slot
);
    import wbrm_pkg::*;

    localparam int RW      = $clog2(WINDOW);
    localparam int CNT_MAX = (WINDOW + 1 > NUM_DIGITS - 1) ? WINDOW + 1 : NUM_DIGITS - 1;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MOD  = 8'b0000_0010,
        S_ARD  = 8'b0000_0100,
        S_AWR  = 8'b0000_1000,
        S_QRD  = 8'b0001_0000,
        S_QLD  = 8'b0010_0000,
        S_QDIV = 8'b0100_0000,
        S_PUT  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_q_slot = r_cnt[RW-1:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_cnt       = '0;
                    n_state     = (i_in_command == CMD_QUERY) ? S_QRD : S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
                    n_state = S_ARD;
                end
            end
            S_ARD: begin
                o_cmd.a_rd = 1'b1;
                n_state    = S_AWR;
            end
            S_AWR: begin
                o_cmd.a_wr = 1'b1;
                n_state    = S_IDLE;
            end
            S_QRD: begin
                o_cmd.q_rd = (r_cnt < CNT_W'(WINDOW));
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WINDOW + 1)) begin
                    n_state = S_QLD;
                end
            end
            S_QLD: begin
                o_cmd.div_load_sum = 1'b1;
                n_cnt              = '0;
                n_state            = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/wbrm_dp.sv =====
// bucket memory, digit-serial divider, window accumulator and result register
// depends on wbrm_pkg
`default_nettype none

module wbrm_dp #(
    parameter int WINDOW = wbrm_pkg::WINDOW_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire wbrm_pkg::t_dp_cmd            i_cmd,
    output wbrm_pkg::t_dp_sts                 o_sts,
    input  wire [$clog2(WINDOW)-1:0]          i_q_slot,
    input  wire                               i_direction,
    input  wire [wbrm_pkg::DATA_W-1:0]        i_byte_count,
    input  wire [wbrm_pkg::DATA_W-1:0]        i_now_secs,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [wbrm_pkg::DATA_W-1:0]       o_bytes_per_sec
);
    import wbrm_pkg::*;

    localparam int RW    = $clog2(WINDOW);
    localparam int MEM_D = 2 * WINDOW;
    localparam int AW    = $clog2(MEM_D);
    localparam int VAL_W = RW + DIGIT_W;
    localparam int TAB_D = 2 ** VAL_W;

    // constant digit tables for division by the window length
    logic [DIGIT_W-1:0] w_qtab [TAB_D];
    logic [RW-1:0]      w_rtab [TAB_D];

    for (genvar v = 0; v < TAB_D; v++) begin : g_tab
        assign w_qtab[v] = DIGIT_W'(v / WINDOW);
        assign w_rtab[v] = RW'(v % WINDOW);
    end

    logic                  r_dir;
    logic [DATA_W-1:0]     r_bytes_in;
    logic [DATA_W-1:0]     r_now;
    logic [DATA_W-1:0]     r_num;
    logic [RW-1:0]         r_rem;
    logic [DATA_W-1:0]     r_quo;
    logic [DATA_W-1:0]     r_sum;
    logic [2*DATA_W-1:0]   r_mem [MEM_D];
    logic [MEM_D-1:0]      r_vld;
    logic [2*DATA_W-1:0]   r_rd_word;
    logic                  r_rd_ok;
    logic                  r_rd_pend;
    logic                  r_hit;
    logic [DATA_W-1:0]     r_hit_bytes;
    logic                  r_hit_pend;
    logic                  r_out_vld;
    logic [DATA_W-1:0]     r_out_data;

    logic [VAL_W-1:0]      w_val;
    logic [RW-1:0]         w_slot;
    logic [AW-1:0]         w_addr;
    logic [DATA_W-1:0]     w_stamp;
    logic [DATA_W-1:0]     w_cnt;
    logic [DATA_W-1:0]     w_age;
    logic                  w_hit;
    logic [DATA_W-1:0]     w_new_cnt;

    assign w_val   = {r_rem, r_num[DATA_W-1 -: DIGIT_W]};
    assign w_slot  = (i_cmd.a_rd || i_cmd.a_wr) ? r_rem : i_q_slot;
    assign w_addr  = (r_dir ? AW'(WINDOW) : AW'(0)) + AW'(w_slot);
    assign w_stamp = r_rd_ok ? r_rd_word[2*DATA_W-1 -: DATA_W] : '0;
    assign w_cnt   = r_rd_ok ? r_rd_word[DATA_W-1:0] : '0;
    assign w_age   = r_now - w_stamp;
    assign w_hit   = (w_stamp != '0) && (w_age[DATA_W-1] || (w_age <= DATA_W'(WINDOW)));
    assign w_new_cnt = (w_stamp == r_now) ? (w_cnt + r_bytes_in) : r_bytes_in;

    // input latch and digit-serial divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_dir      <= i_direction;
            r_bytes_in <= i_byte_count;
            r_now      <= i_now_secs;
            r_num      <= i_now_secs;
            r_rem      <= '0;
        end else if (i_cmd.div_load_sum) begin
            r_num <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << DIGIT_W;
            r_rem <= w_rtab[w_val];
            r_quo <= {r_quo[DATA_W-DIGIT_W-1:0], w_qtab[w_val]};
        end
    end

    // bucket memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.a_wr) begin
            r_mem[w_addr] <= {r_now, w_new_cnt};
        end
        r_rd_word <= r_mem[w_addr];
        r_rd_ok   <= r_vld[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.a_wr) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    // window scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend  <= 1'b0;
            r_hit_pend <= 1'b0;
        end else begin
            r_rd_pend  <= i_cmd.q_rd;
            r_hit_pend <= r_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit       <= w_hit;
        r_hit_bytes <= w_cnt;
        if (i_cmd.latch) begin
            r_sum <= '0;
        end else if (r_hit_pend && r_hit) begin
            r_sum <= r_sum + r_hit_bytes;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_quo;
        end
    end

    assign o_sts.out_full  = r_out_vld;
    assign o_out_valid     = r_out_vld;
    assign o_bytes_per_sec = r_out_data;

endmodule

`default_nettype wire
